### hdl/csvsp_pkg.sv
// ----------------------------------------------------------------------------
// csvsp_pkg
// Shared types and constants of the CSV status field parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csvsp_pkg;

  // Payload widths
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 3;
  localparam int VAL_W       = 32;
  localparam int OUT_TDATA_W = 40;

  // Characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;

  // Number scanner phases
  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Field values for bad fields and status words
  localparam logic [VAL_W-1:0] VAL_BAD = 32'hFFFF_FFFF;  // -1
  localparam logic [VAL_W-1:0] VAL_PO  = 32'hFFFF_FFFE;  // -2
  localparam logic [VAL_W-1:0] VAL_RE  = 32'hFFFF_FFFD;  // -3
  localparam logic [VAL_W-1:0] VAL_FE  = 32'hFFFF_FFFC;  // -4
  localparam logic [VAL_W-1:0] VAL_FB  = 32'hFFFF_FFFB;  // -5
  localparam logic [VAL_W-1:0] VAL_SE  = 32'hFFFF_FFFA;  // -6
  localparam logic [VAL_W-1:0] VAL_BEG = 32'hFFFF_FFF9;  // -7
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  // Saturation bound of the magnitude (2^31) on the widened product
  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

  // Characters counted per field: enough to tell zero, one..three, four plus
  localparam logic [2:0] CHARS_SAT = 3'd4;

  // Classified byte, queued between front and back
  typedef struct packed {
    logic [7:0] ch;
    logic       comma;
    logic       last;
    logic       digit;
    logic       space;
    logic       sign;
    logic       minus;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

### hdl/csv_status_field_parser.sv
// ----------------------------------------------------------------------------
// csv_status_field_parser
// Splits a byte stream of a sensor reply into comma separated fields and
// returns each field's index, value or status code.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                   | tlast
//  s_axis  | in  | rx_byte[7:0]                         | last_byte
//  m_axis  | out | field_index[2:0], field_value[34:3],  | record_end
//          |     | zero pad [39:35]                     |
//
//  One byte per cycle is accepted while the queue has room. The field
//  engine takes in each byte and, after taking a last byte, closes the
//  record in a further step while that byte is still held in the queue.
//  Each closed field waits in one output register; a full register stalls
//  the engine at its next close, and the QUEUE_DEPTH deep queue absorbs input.
//  rst is synchronous and clears the queue, field state and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_status_field_parser #(
  parameter int FIELD_LIMIT = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // field_index[2:0], field_value[34:3], pad
  output logic        m_tlast
);

  csvsp_pkg::cmd_t              front_cmd;
  csvsp_pkg::cmd_t              back_cmd;
  logic [csvsp_pkg::CMD_W-1:0]  q_rd;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_valid;
  logic                         second_step;

  // Classify incoming beats
  csvsp_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .rx_byte   (s_tdata),
    .last_byte (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .cmd       (front_cmd)
  );

  // Decouple classifier from field engine
  csvsp_fifo #(
    .WIDTH (csvsp_pkg::CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (front_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .valid   (q_valid)
  );

  assign back_cmd = csvsp_pkg::cmd_t'(q_rd);

  // Scan fields and drive results
  csvsp_back #(
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .cmd         (back_cmd),
    .q_pop       (q_pop),
    .second_step (second_step),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  // A stalled input side means the engine has queued work
  a_full_has_work: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("queue full but engine sees no command");

  // The record-closing step works on a command still held in the queue
  a_second_held: assert property (@(posedge clk) disable iff (rst)
    second_step |-> q_valid)
    else $error("record close step without a queued command");

  // An accepted beat is queued on the next cycle
  a_beat_queued: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> q_valid)
    else $error("accepted beat missing from queue");

endmodule

### hdl/csvsp_fifo.sv
// ----------------------------------------------------------------------------
// csvsp_fifo
// Small register queue between the classifier and the field engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvsp_fifo #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];

  // Store a beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/csvsp_front.sv
// ----------------------------------------------------------------------------
// csvsp_front
// Input side: accepts bytes and classifies each into a queue command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvsp_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        rx_byte,
  input  logic              last_byte,
  input  logic              q_full,
  output logic              q_push,
  output csvsp_pkg::cmd_t   cmd
);

  // Accept whenever the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Classify the byte
  always_comb begin
    cmd.ch    = rx_byte;
    cmd.last  = last_byte;
    cmd.comma = (rx_byte == csvsp_pkg::CH_COMMA);
    cmd.digit = (rx_byte >= csvsp_pkg::CH_ZERO) && (rx_byte <= csvsp_pkg::CH_NINE);
    cmd.space = (rx_byte == csvsp_pkg::CH_SPACE) ||
                ((rx_byte >= csvsp_pkg::CH_TAB) && (rx_byte <= csvsp_pkg::CH_CR));
    cmd.minus = (rx_byte == csvsp_pkg::CH_MINUS);
    cmd.sign  = (rx_byte == csvsp_pkg::CH_PLUS) || cmd.minus;
  end

endmodule

### hdl/csvsp_back.sv
// ----------------------------------------------------------------------------
// csvsp_back
// Field engine: scans queued bytes, closes fields and drives result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvsp_back #(
  parameter int FIELD_LIMIT = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  csvsp_pkg::cmd_t                      cmd,
  output logic                                 q_pop,
  output logic                                 second_step,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [csvsp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                 m_tlast
);

  localparam int CNT_W = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FIELD_LIMIT - 1);

  // Field state
  logic [2:0]                     chars;
  logic [7:0]                     c0;
  logic [7:0]                     c1;
  logic [7:0]                     c2;
  logic [1:0]                     phase;
  logic                           negative;
  logic [31:0]                    magnitude;
  logic                           overflowed;
  logic [CNT_W-1:0]               counter;
  logic                           second;

  logic                           out_free;
  logic                           do_close;
  logic                           close_end;
  logic                           step;
  logic [35:0]                    prod;
  logic                           prod_sat;
  logic                           bad;
  logic [csvsp_pkg::VAL_W-1:0]    status_val;
  logic [csvsp_pkg::VAL_W-1:0]    value;
  logic [CNT_W+2:0]               idx_ext;

  assign second_step = second;
  assign out_free    = !m_tvalid || m_tready;

  // First step of a comma closes a field; the second step closes the record
  assign close_end = second;
  assign do_close  = second || cmd.comma;
  assign step      = q_valid && (!do_close || out_free);
  assign q_pop     = step && (second || !cmd.last);

  // Multiply-add of one digit: m*10 + d
  assign prod     = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1) +
                    {32'b0, cmd.ch[3:0]};
  assign prod_sat = (prod > csvsp_pkg::MAG_LIMIT);

  // Status word from the first three characters of a field of four or more
  always_comb begin
    status_val = csvsp_pkg::VAL_BAD;
    if (chars == csvsp_pkg::CHARS_SAT) begin
      if (c0 == csvsp_pkg::CH_P && c1 == csvsp_pkg::CH_UNDER && c2 == csvsp_pkg::CH_O) begin
        status_val = csvsp_pkg::VAL_PO;
      end else if (c0 == csvsp_pkg::CH_R && c1 == csvsp_pkg::CH_UNDER &&
                   c2 == csvsp_pkg::CH_E) begin
        status_val = csvsp_pkg::VAL_RE;
      end else if (c0 == csvsp_pkg::CH_F && c1 == csvsp_pkg::CH_UNDER &&
                   c2 == csvsp_pkg::CH_E) begin
        status_val = csvsp_pkg::VAL_FE;
      end else if (c0 == csvsp_pkg::CH_F && c1 == csvsp_pkg::CH_UNDER &&
                   c2 == csvsp_pkg::CH_B) begin
        status_val = csvsp_pkg::VAL_FB;
      end else if (c0 == csvsp_pkg::CH_S && c1 == csvsp_pkg::CH_UNDER &&
                   c2 == csvsp_pkg::CH_E) begin
        status_val = csvsp_pkg::VAL_SE;
      end else if (c0 == csvsp_pkg::CH_B && c1 == csvsp_pkg::CH_E &&
                   c2 == csvsp_pkg::CH_G) begin
        status_val = csvsp_pkg::VAL_BEG;
      end
    end
  end

  // Value of the field being closed
  assign bad = (chars == 3'd0) || (c0 > csvsp_pkg::CH_NINE);
  always_comb begin
    if (bad) begin
      value = status_val;
    end else if (negative) begin
      value = overflowed ? csvsp_pkg::VAL_MIN : (32'd0 - magnitude);
    end else if (overflowed || magnitude[31]) begin
      value = csvsp_pkg::VAL_MAX;
    end else begin
      value = magnitude;
    end
  end

  assign idx_ext = {3'b000, counter};

  // Scan, close and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      second     <= 1'b0;
      counter    <= '0;
      chars      <= '0;
      c0         <= '0;
      c1         <= '0;
      c2         <= '0;
      phase      <= csvsp_pkg::PH_SPACE;
      negative   <= 1'b0;
      magnitude  <= '0;
      overflowed <= 1'b0;
    end else begin
      // Load a closed field, or retire the beat the receiver took
      if (step && do_close) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (step) begin
        second <= !second && cmd.last;
        if (do_close) begin
          // Emit the field and clear it
          m_tdata    <= {5'b0, value, idx_ext[2:0]};
          m_tlast    <= close_end;
          chars      <= '0;
          c0         <= '0;
          c1         <= '0;
          c2         <= '0;
          phase      <= csvsp_pkg::PH_SPACE;
          negative   <= 1'b0;
          magnitude  <= '0;
          overflowed <= 1'b0;
          if (close_end) begin
            counter <= '0;
          end else if (counter != CNT_LAST) begin
            counter <= counter + 1'b1;
          end
        end else begin
          // Take the byte into the field
          case (chars)
            3'd0:    c0 <= cmd.ch;
            3'd1:    c1 <= cmd.ch;
            3'd2:    c2 <= cmd.ch;
            default: ;
          endcase
          if (chars != csvsp_pkg::CHARS_SAT) begin
            chars <= chars + 1'b1;
          end
          case (phase)
            csvsp_pkg::PH_SPACE: begin
              if (cmd.space) begin
                phase <= csvsp_pkg::PH_SPACE;
              end else if (cmd.sign) begin
                negative <= cmd.minus;
                phase    <= csvsp_pkg::PH_SIGN;
              end else if (cmd.digit) begin
                phase     <= csvsp_pkg::PH_DIGITS;
                magnitude <= prod_sat ? csvsp_pkg::VAL_MIN : prod[31:0];
                if (prod_sat) begin
                  overflowed <= 1'b1;
                end
              end else begin
                phase <= csvsp_pkg::PH_DONE;
              end
            end
            csvsp_pkg::PH_SIGN, csvsp_pkg::PH_DIGITS: begin
              if (cmd.digit) begin
                phase     <= csvsp_pkg::PH_DIGITS;
                magnitude <= prod_sat ? csvsp_pkg::VAL_MIN : prod[31:0];
                if (prod_sat) begin
                  overflowed <= 1'b1;
                end
              end else begin
                phase <= csvsp_pkg::PH_DONE;
              end
            end
            default: begin
              phase <= csvsp_pkg::PH_DONE;
            end
          endcase
        end
      end
    end
  end

endmodule
